### src/frua_pkg.sv
// Shared types and constants for the frame ring upload allocator.
package frua_pkg;

   localparam logic [1:0] FUNC_ALLOC     = 2'd0;
   localparam logic [1:0] FUNC_FRAME_END = 2'd1;
   localparam logic [1:0] FUNC_RESET     = 2'd2;

   localparam logic [31:0] BUFFER_BYTES_RESET = 32'd1048576;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] size;
      logic [16:0] alignment;
   } req_type;

   typedef struct packed {
      logic [31:0] offset;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic align;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic req_alloc;
      logic req_aligned;
      logic div_last;
   } sts_type;

endpackage

### src/frua_dp.sv
// Allocator datapath: request register, remainder unit, ring state and response register.
module frua_dp #(
   parameter int FRAMES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  frua_pkg::req_type req_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  frua_pkg::cmd_type cmd,
   output frua_pkg::sts_type sts,
   output frua_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(FRAMES);

   logic [31:0]       buffer_bytes_ff;
   logic [31:0]       write_offset_ff;
   logic [31:0]       free_limit_ff;
   logic [SLOT_W-1:0] frame_slot_ff;
   logic [31:0]       frame_end_ff [FRAMES];

   logic [1:0]        func_ff;
   logic [31:0]       size_ff;
   logic [16:0]       align_ff;
   logic [16:0]       rem_ff;
   logic [4:0]        cnt_ff;
   logic [32:0]       start_ff;
   frua_pkg::rsp_type rsp_ff;

   logic [17:0]       trial;
   logic [16:0]       rem_in;
   logic [16:0]       pad;
   logic [SLOT_W-1:0] slot_next;
   logic [33:0]       end_raw;
   logic [33:0]       end_fin;
   logic [32:0]       start_fin;
   logic [31:0]       upper;
   logic              wrapped;
   logic              overflow_in;

   assign sts.req_alloc   = (req_data.func == frua_pkg::FUNC_ALLOC);
   assign sts.req_aligned = (req_data.alignment != 17'd0);
   assign sts.div_last    = (cnt_ff == 5'd31);
   assign rsp_data        = rsp_ff;

   // one remainder bit per cycle, dividend taken MSB first
   assign trial  = {rem_ff, write_offset_ff[~cnt_ff]};
   assign rem_in = (trial >= {1'b0, align_ff}) ? 17'(trial - {1'b0, align_ff}) : trial[16:0];

   assign pad = (align_ff == 17'd0 || rem_ff == 17'd0) ? 17'd0 : align_ff - rem_ff;

   assign slot_next = (frame_slot_ff == SLOT_W'(FRAMES - 1)) ? '0 : frame_slot_ff + 1'b1;

   always_comb begin
      wrapped   = write_offset_ff < free_limit_ff;
      end_raw   = {1'b0, start_ff} + {2'b00, size_ff};
      start_fin = start_ff;
      end_fin   = end_raw;
      upper     = wrapped ? free_limit_ff : buffer_bytes_ff;
      if (!wrapped && end_raw > {2'b00, buffer_bytes_ff}) begin
         start_fin = '0;
         end_fin   = {2'b00, size_ff};
         upper     = free_limit_ff;
      end
      overflow_in = end_fin > {2'b00, upper};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff <= frua_pkg::BUFFER_BYTES_RESET;
         write_offset_ff <= '0;
         free_limit_ff   <= '0;
         frame_slot_ff   <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            frame_end_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            buffer_bytes_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            unique case (func_ff)
               frua_pkg::FUNC_ALLOC: begin
                  if (!overflow_in) begin
                     write_offset_ff <= end_fin[31:0];
                  end
               end
               frua_pkg::FUNC_FRAME_END: begin
                  frame_slot_ff               <= slot_next;
                  free_limit_ff               <= frame_end_ff[slot_next];
                  frame_end_ff[frame_slot_ff] <= write_offset_ff;
               end
               frua_pkg::FUNC_RESET: begin
                  write_offset_ff <= '0;
                  free_limit_ff   <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_data.func;
         size_ff  <= req_data.size;
         align_ff <= req_data.alignment;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.align) begin
         start_ff <= {1'b0, write_offset_ff} + {16'd0, pad};
      end
      if (cmd.commit) begin
         rsp_ff.offset   <= (func_ff == frua_pkg::FUNC_ALLOC && !overflow_in) ?
                            start_fin[31:0] : 32'd0;
         rsp_ff.overflow <= (func_ff == frua_pkg::FUNC_ALLOC) && overflow_in;
      end
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < align_ff)
      else $error("remainder not below alignment");

   a_grant_below_offset: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && func_ff == frua_pkg::FUNC_ALLOC && !overflow_in
      |=> rsp_ff.offset <= write_offset_ff)
      else $error("granted region ends before its start");

   a_limit_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && func_ff == frua_pkg::FUNC_FRAME_END
      |=> free_limit_ff == $past(frame_end_ff[slot_next]))
      else $error("limit not loaded from next slot");

endmodule

### src/frua_ctrl.sv
// Allocator control state machine: request intake, remainder sequencing, response handoff.
module frua_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  frua_pkg::sts_type sts,
   output frua_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      ALIGN,
      COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      accept;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cmd.load     = accept;
   assign cmd.div_step = (state_ff == DIVIDE);
   assign cmd.align    = (state_ff == ALIGN);
   assign cmd.commit   = (state_ff == COMMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (!sts.req_alloc) begin
                     state_ff <= COMMIT;
                  end else if (sts.req_aligned) begin
                     state_ff <= DIVIDE;
                  end else begin
                     state_ff <= ALIGN;
                  end
               end
            end
            DIVIDE: begin
               if (sts.div_last) begin
                  state_ff <= ALIGN;
               end
            end
            ALIGN: begin
               state_ff <= COMMIT;
            end
            COMMIT: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while busy");

   a_commit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without response");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.align, cmd.commit}))
      else $error("overlapping datapath commands");

endmodule

### src/frame_ring_upload_allocator_top.sv
// Frame ring upload allocator: one request in, one response out, per request.
// Allocate with nonzero alignment: bit-serial remainder unit, then align and commit steps;
// other allocates take only the align and commit steps, others only commit.
// One request in flight at a time; the next is accepted when the response is registered.
// Synchronous reset clears offset, limit, frame slot and recorded frame ends; size to 1 MiB.
module frame_ring_upload_allocator_top #(
   parameter int FRAMES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  frua_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output frua_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   frua_pkg::cmd_type cmd;
   frua_pkg::sts_type sts;

   frua_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   frua_dp #(
      .FRAMES (FRAMES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

### bench/tb.sv
// Self-checking bench for the frame ring upload allocator: directed table, then random requests.
`timescale 1ns / 1ps

module tb;

   localparam int FRAMES = 3;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 7;
   localparam int RANDOM_PER_PHASE = 100;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      frua_pkg::req_type req;
      bit                typed;
      frua_pkg::rsp_type want;
   } vector_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   frua_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   frua_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   logic [31:0] ring_size = frua_pkg::BUFFER_BYTES_RESET;
   logic [31:0] ring_wr_ofs = '0;
   logic [31:0] ring_limit = '0;
   logic [1:0]  ring_slot = '0;
   logic [31:0] ring_frame_ends [FRAMES] = '{default: '0};

   frua_pkg::rsp_type grants_due [$];
   vector_row_type    directed [$];
   int          errors = 0;
   int          idle_pct = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   int          phase_idle [PHASES] = '{15, 25, 0, 10, 30, 20, 0};
   logic [31:0] phase_size [PHASES] = '{frua_pkg::BUFFER_BYTES_RESET, 32'hFFFF_FFFF, 32'd1,
                                        32'd0, 32'd4096, 32'd196613, 32'd0};

   frame_ring_upload_allocator_top #(.FRAMES(FRAMES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic frua_pkg::rsp_type predict_grant(frua_pkg::req_type r);
      logic [32:0] begin_at;
      logic [32:0] ceiling;
      logic [31:0] rem;
      int unsigned cur;
      int unsigned nxt;
      int unsigned prv;
      frua_pkg::rsp_type g;
      g = '0;
      case (r.func)
         frua_pkg::FUNC_ALLOC: begin
            begin_at = {1'b0, ring_wr_ofs};
            if (r.alignment != '0) begin
               rem = ring_wr_ofs % {15'd0, r.alignment};
               if (rem != '0)
                  begin_at = {1'b0, ring_wr_ofs} + {16'd0, r.alignment} - {1'b0, rem};
            end
            ceiling = (ring_wr_ofs < ring_limit) ? {1'b0, ring_limit} : {1'b0, ring_size};
            if (ring_wr_ofs >= ring_limit &&
                {1'b0, begin_at} + {2'b00, r.size} > {2'b00, ring_size}) begin
               begin_at = '0;
               ceiling = {1'b0, ring_limit};
            end
            if ({1'b0, begin_at} + {2'b00, r.size} > {1'b0, ceiling}) begin
               g.overflow = 1'b1;
            end else begin
               ring_wr_ofs = begin_at[31:0] + r.size;
               g.offset = begin_at[31:0];
            end
         end
         frua_pkg::FUNC_FRAME_END: begin
            cur = (ring_slot < FRAMES) ? ring_slot : 0;
            nxt = (cur + 1) % FRAMES;
            prv = (nxt + FRAMES - 1) % FRAMES;
            ring_slot = nxt[1:0];
            ring_limit = ring_frame_ends[nxt];
            ring_frame_ends[prv] = ring_wr_ofs;
         end
         frua_pkg::FUNC_RESET: begin
            ring_wr_ofs = '0;
            ring_limit = '0;
         end
         default: ;
      endcase
      return g;
   endfunction

   function automatic vector_row_type row(logic [1:0] f, logic [31:0] sz, logic [16:0] al,
                                          bit typed, logic [31:0] ofs, logic ovf);
      vector_row_type v;
      v.req.func = f;
      v.req.size = sz;
      v.req.alignment = al;
      v.typed = typed;
      v.want.offset = ofs;
      v.want.overflow = ovf;
      return v;
   endfunction

   task automatic issue(input frua_pkg::req_type r, input bit typed,
                        input frua_pkg::rsp_type want);
      frua_pkg::rsp_type g;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      g = predict_grant(r);
      grants_due.push_back(typed ? want : g);
   endtask

   // response-side backpressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!reset && $urandom_range(0, 399) < idle_pct) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frua_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grants_due.size() == 0) begin
            $display("%0t: unexpected response offset=%h overflow=%b",
                     $time, rsp_data.offset, rsp_data.overflow);
            errors = errors + 1;
         end else begin
            want = grants_due.pop_front();
            if (rsp_data.offset !== want.offset) begin
               $display("%0t: offset expected %h actual %h", $time, want.offset, rsp_data.offset);
               errors = errors + 1;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $display("%0t: overflow expected %b actual %b",
                        $time, want.overflow, rsp_data.overflow);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      frua_pkg::req_type r;
      logic [31:0]       new_size;
      int                pick;

      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd0, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd100, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd10, 17'd64, 1, 32'd128, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd5, 17'd7, 0, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'hFFFF_FFFF, 17'd0, 1, 32'd0, 1));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd1, 17'd65536, 1, 32'd65536, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd2, 17'h1FFFF, 0, 32'd0, 0));
      directed.push_back(row(FUNC_UNUSED,              32'hFFFF_FFFF, 17'h1FFFF, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_FRAME_END, 32'd0, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_FRAME_END, 32'd0, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_FRAME_END, 32'd0, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd917503, 17'd0, 1, 32'd131073, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd1, 17'd0, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd131073, 17'd0, 1, 32'd0, 1));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd131072, 17'd1, 0, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_RESET,     32'hFFFF_FFFF, 17'h1FFFF, 1, 32'd0, 0));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'hFFFF_FFFF, 17'h1FFFF, 1, 32'd0, 1));
      directed.push_back(row(frua_pkg::FUNC_ALLOC,     32'd0, 17'd1, 1, 32'd0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_pct = phase_idle[ph];
         if (ph != 0) begin
            new_size = (ph == PHASES - 1) ? $urandom_range(2, 1 << 20) : phase_size[ph];
            csr_wr_en <= 1'b1;
            csr_wr_data <= new_size;
            @(posedge clock);
            csr_wr_en <= 1'b0;
            ring_size = new_size;
         end
         if (ph == 0)
            foreach (directed[i]) issue(directed[i].req, directed[i].typed, directed[i].want);
         repeat (RANDOM_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 74)      r.func = frua_pkg::FUNC_ALLOC;
            else if (pick < 90) r.func = frua_pkg::FUNC_FRAME_END;
            else if (pick < 95) r.func = frua_pkg::FUNC_RESET;
            else                r.func = FUNC_UNUSED;
            case ($urandom_range(0, 9))
               0:       r.size = $urandom;
               1:       r.size = '0;
               default: r.size = $urandom_range(0, (ring_size >> 3) + 1);
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2, 3: r.alignment = '0;
               4, 5, 6:    r.alignment = 17'd1 << $urandom_range(0, 16);
               7, 8:       r.alignment = 17'($urandom_range(1, 65536));
               default:    r.alignment = 17'($urandom);
            endcase
            issue(r, 1'b0, '0);
         end
         req_valid <= 1'b0;
         while (grants_due.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end

      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
src/frua_pkg.sv
src/frua_dp.sv
src/frua_ctrl.sv
src/frame_ring_upload_allocator_top.sv
bench/tb.sv
